FILE: rtl/geo2ecef_pkg.sv
// Shared types, constants and the arctangent table for the geodetic to ECEF unit.
`default_nettype none
package geo2ecef_pkg;

	localparam int TRIG_ITERATIONS_DEF = 24;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 62;
	localparam int MUL_LAT = 4;

	localparam logic [31:0] SEMI_MAJOR_RESET = 32'd1632803072;
	localparam logic [31:0] AXIS_RATIO_RESET = 32'd4266215146;

	// Register select by word address bit.
	localparam logic REG_SEMI_MAJOR = 1'b0;
	localparam logic REG_AXIS_RATIO = 1'b1;

	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [36:0] PI_Q32 = 37'sd13493037704;
	localparam logic signed [36:0] HALF_PI_Q32 = 37'sd6746518852;
	localparam logic [61:0] N_LIMIT = 62'h2000_0000_0000_0000;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [36:0] z;
	} rot_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [35:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [61:0] num;
		logic [31:0] rem;
		logic [31:0] den;
	} dv_t;

	typedef struct packed {
		logic signed [31:0] h;
		logic nlat;
		logic nlon;
		logic signed [33:0] cl;
		logic signed [33:0] sl;
		logic signed [33:0] co;
		logic signed [33:0] so;
	} side_t;

	typedef logic [31:0] atan_tab_t [32];

	// Entry i is atan(2^-i) in units of 2^-32 rad, from the Taylor series at 2^-60.
	function automatic atan_tab_t build_atan();
		atan_tab_t t;
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		t[0] = 32'd3373259426;
		for (int i = 1; i < 32; i++) begin
			p = 64'd1 << (60 - i);
			sum = '0;
			for (int n = 0; n < 32; n++) begin
				if (p != 64'd0) begin
					term = p / 64'(2 * n + 1);
					if (n[0]) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
					p = p >> (2 * i);
				end
			end
			t[i] = 32'((sum + (64'd1 << 27)) >> 28);
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage
`default_nettype wire

FILE: rtl/geodetic_to_ecef_unit.sv
// Top level of the geodetic to ECEF conversion pipeline.
// Takes one position per cycle unless stalled and returns X, Y, Z; the pipeline is made of
// the two CORDIC rotator chains, the 32-cell square root chain and the 62-cell divider chain,
// with four-stage rounding multipliers around them.
// The whole pipeline holds while a result waits on m_tready. Registers: semi_major_axis at
// address 0, axis_ratio_squared at address 4; write them only while the unit is empty.
`default_nettype none
module geodetic_to_ecef_unit #(
	parameter int TRIG_ITERATIONS = geo2ecef_pkg::TRIG_ITERATIONS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [95:0]  s_tdata,   // longitude[31:0], latitude[62:32], height[94:63], zero
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [119:0] m_tdata,   // ecef_x[39:0], ecef_y[79:40], ecef_z[119:80]
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int ML = geo2ecef_pkg::MUL_LAT;
	localparam int FOLD = 1;
	localparam int CORD = FOLD + TRIG_ITERATIONS;
	localparam int NEG = CORD + 1;
	localparam int SQR = NEG + 1;
	localparam int KS = SQR + ML;
	localparam int DSUM = KS + 1;
	localparam int SQRT = DSUM + geo2ecef_pkg::SQRT_STEPS;
	localparam int DIVO = SQRT + geo2ecef_pkg::DIV_STEPS;
	localparam int CLMP = DIVO + 1;
	localparam int PM = CLMP + ML;
	localparam int T2 = PM + 1;
	localparam int XYZ = T2 + ML;
	localparam int LAT = XYZ + 1;
	localparam int SIDE_LEN = T2;

	logic [31:0] semi_major_q;
	logic [31:0] axis_ratio_q;
	logic        adv;
	logic [LAT-1:0] vld_q;

	geo2ecef_pkg::side_t side_q [SIDE_LEN];
	geo2ecef_pkg::rot_t  lat_r [TRIG_ITERATIONS+1];
	geo2ecef_pkg::rot_t  lon_r [TRIG_ITERATIONS+1];
	geo2ecef_pkg::sq_t   sq [geo2ecef_pkg::SQRT_STEPS+1];
	geo2ecef_pkg::dv_t   dv [geo2ecef_pkg::DIV_STEPS+1];

	logic signed [30:0] lat_in;
	logic signed [31:0] lon_in;
	logic signed [36:0] zlat;
	logic signed [36:0] zlon;
	logic [33:0] clm;
	logic [33:0] slm;
	logic [63:0] c2_q [ML+1];
	logic [63:0] s2_q;
	logic signed [63:0] ks;
	logic [61:0] quo;
	logic [61:0] n_q;
	logic signed [63:0] t1_q;
	logic signed [63:0] pc;
	logic signed [63:0] m;
	logic signed [63:0] p_q;
	logic signed [63:0] t2_q;
	logic signed [63:0] xv;
	logic signed [63:0] yv;
	logic signed [63:0] zv;

	function automatic logic [39:0] sat40(input logic signed [63:0] v);
		logic [39:0] r;
		if (!v[63] && (|v[62:39])) begin
			r = 40'h7F_FFFF_FFFF;
		end else if (v[63] && !(&v[62:39])) begin
			r = 40'h80_0000_0000;
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			semi_major_q <= geo2ecef_pkg::SEMI_MAJOR_RESET;
			axis_ratio_q <= geo2ecef_pkg::AXIS_RATIO_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				geo2ecef_pkg::REG_SEMI_MAJOR: semi_major_q <= pwdata;
				geo2ecef_pkg::REG_AXIS_RATIO: axis_ratio_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			geo2ecef_pkg::REG_SEMI_MAJOR: prdata = semi_major_q;
			geo2ecef_pkg::REG_AXIS_RATIO: prdata = axis_ratio_q;
			default: prdata = '0;
		endcase
	end

	// Flow control: every stage advances together.
	assign m_tvalid = vld_q[LAT-1];
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Angle fold: beyond a quarter turn, rotate by half a turn and negate the results.
	always_comb begin
		lon_in = s_tdata[31:0];
		lat_in = s_tdata[62:32];
		zlon = {{2{lon_in[31]}}, lon_in, 3'b000};
		zlat = {{3{lat_in[30]}}, lat_in, 3'b000};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_r[0].x <= geo2ecef_pkg::GAIN_Q30;
			lat_r[0].y <= '0;
			lon_r[0].x <= geo2ecef_pkg::GAIN_Q30;
			lon_r[0].y <= '0;
			if (zlat > geo2ecef_pkg::HALF_PI_Q32) begin
				lat_r[0].z <= zlat - geo2ecef_pkg::PI_Q32;
			end else if (zlat < -geo2ecef_pkg::HALF_PI_Q32) begin
				lat_r[0].z <= zlat + geo2ecef_pkg::PI_Q32;
			end else begin
				lat_r[0].z <= zlat;
			end
			if (zlon > geo2ecef_pkg::HALF_PI_Q32) begin
				lon_r[0].z <= zlon - geo2ecef_pkg::PI_Q32;
			end else if (zlon < -geo2ecef_pkg::HALF_PI_Q32) begin
				lon_r[0].z <= zlon + geo2ecef_pkg::PI_Q32;
			end else begin
				lon_r[0].z <= zlon;
			end
		end
	end

	// Side data travels beside the arithmetic; trig values join once CORDIC is done.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0].h <= s_tdata[94:63];
			side_q[0].nlat <= (zlat > geo2ecef_pkg::HALF_PI_Q32) ||
				(zlat < -geo2ecef_pkg::HALF_PI_Q32);
			side_q[0].nlon <= (zlon > geo2ecef_pkg::HALF_PI_Q32) ||
				(zlon < -geo2ecef_pkg::HALF_PI_Q32);
			side_q[0].cl <= '0;
			side_q[0].sl <= '0;
			side_q[0].co <= '0;
			side_q[0].so <= '0;
			for (int j = 1; j < SIDE_LEN; j++) begin
				if (j == NEG - 1) begin
					side_q[j].h <= side_q[j-1].h;
					side_q[j].nlat <= side_q[j-1].nlat;
					side_q[j].nlon <= side_q[j-1].nlon;
					side_q[j].cl <= side_q[j-1].nlat ? -lat_r[TRIG_ITERATIONS].x :
						lat_r[TRIG_ITERATIONS].x;
					side_q[j].sl <= side_q[j-1].nlat ? -lat_r[TRIG_ITERATIONS].y :
						lat_r[TRIG_ITERATIONS].y;
					side_q[j].co <= side_q[j-1].nlon ? -lon_r[TRIG_ITERATIONS].x :
						lon_r[TRIG_ITERATIONS].x;
					side_q[j].so <= side_q[j-1].nlon ? -lon_r[TRIG_ITERATIONS].y :
						lon_r[TRIG_ITERATIONS].y;
				end else begin
					side_q[j] <= side_q[j-1];
				end
			end
		end
	end

	for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
		geo2ecef_cordic_cell #(.STAGE(i)) u_lat (
			.clk  (clk),
			.en   (adv),
			.rin  (lat_r[i]),
			.rout (lat_r[i+1])
		);
		geo2ecef_cordic_cell #(.STAGE(i)) u_lon (
			.clk  (clk),
			.en   (adv),
			.rin  (lon_r[i]),
			.rout (lon_r[i+1])
		);
	end

	// Squares of the latitude terms, then D = cos^2 + k*sin^2.
	always_comb begin
		clm = side_q[NEG-1].cl[33] ? -side_q[NEG-1].cl : side_q[NEG-1].cl;
		slm = side_q[NEG-1].sl[33] ? -side_q[NEG-1].sl : side_q[NEG-1].sl;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c2_q[0] <= {32'b0, clm[31:0]} * {32'b0, clm[31:0]};
			s2_q <= {32'b0, slm[31:0]} * {32'b0, slm[31:0]};
			for (int j = 1; j <= ML; j++) begin
				c2_q[j] <= c2_q[j-1];
			end
		end
	end

	geo2ecef_mul_rnd #(.SHIFT(32)) u_mul_ks (
		.clk (clk),
		.en  (adv),
		.a   ($signed(s2_q)),
		.b   ($signed({2'b00, axis_ratio_q})),
		.p   (ks)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq[0].rad <= c2_q[ML] + ks;
			sq[0].rem <= '0;
			sq[0].root <= '0;
		end
	end

	for (genvar i = 0; i < geo2ecef_pkg::SQRT_STEPS; i++) begin : g_sqrt
		geo2ecef_sqrt_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.din  (sq[i]),
			.dout (sq[i+1])
		);
	end

	// N = a * 2^30 / r. A zero root gives an all-ones quotient, which the clamp catches.
	always_comb begin
		dv[0].num = {semi_major_q, 30'b0};
		dv[0].rem = '0;
		dv[0].den = sq[geo2ecef_pkg::SQRT_STEPS].root;
	end

	for (genvar i = 0; i < geo2ecef_pkg::DIV_STEPS; i++) begin : g_div
		geo2ecef_div_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.din  (dv[i]),
			.dout (dv[i+1])
		);
	end

	assign quo = (dv[geo2ecef_pkg::DIV_STEPS].num > geo2ecef_pkg::N_LIMIT) ?
		geo2ecef_pkg::N_LIMIT : dv[geo2ecef_pkg::DIV_STEPS].num;

	always_ff @(posedge clk) begin
		if (adv) begin
			n_q <= quo;
			t1_q <= $signed({2'b00, quo}) + 64'(side_q[DIVO-1].h);
		end
	end

	geo2ecef_mul_rnd #(.SHIFT(30)) u_mul_p (
		.clk (clk),
		.en  (adv),
		.a   (t1_q),
		.b   (side_q[CLMP-1].cl),
		.p   (pc)
	);

	geo2ecef_mul_rnd #(.SHIFT(32)) u_mul_m (
		.clk (clk),
		.en  (adv),
		.a   ($signed({2'b00, n_q})),
		.b   ($signed({2'b00, axis_ratio_q})),
		.p   (m)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_q <= pc;
			t2_q <= m + 64'(side_q[PM-1].h);
		end
	end

	geo2ecef_mul_rnd #(.SHIFT(30)) u_mul_x (
		.clk (clk),
		.en  (adv),
		.a   (p_q),
		.b   (side_q[T2-1].co),
		.p   (xv)
	);

	geo2ecef_mul_rnd #(.SHIFT(30)) u_mul_y (
		.clk (clk),
		.en  (adv),
		.a   (p_q),
		.b   (side_q[T2-1].so),
		.p   (yv)
	);

	geo2ecef_mul_rnd #(.SHIFT(30)) u_mul_z (
		.clk (clk),
		.en  (adv),
		.a   (t2_q),
		.b   (side_q[T2-1].sl),
		.p   (zv)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {sat40(zv), sat40(yv), sat40(xv)};
		end
	end

	// The square root remainder never exceeds twice the root.
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SQRT-1] |-> (sq[geo2ecef_pkg::SQRT_STEPS].rem <=
			{3'b000, sq[geo2ecef_pkg::SQRT_STEPS].root, 1'b0}))
		else $error("square root remainder out of bounds");

	// With a nonzero divisor the divider remainder stays below it.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[DIVO-1] && (dv[geo2ecef_pkg::DIV_STEPS].den != 32'd0)) |->
			(dv[geo2ecef_pkg::DIV_STEPS].rem < dv[geo2ecef_pkg::DIV_STEPS].den))
		else $error("divider remainder not below divisor");

	// A stall freezes the valid bits of every pipeline stage.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

FILE: rtl/geo2ecef_cordic_cell.sv
// One rotation step of the sine/cosine CORDIC chain.
`default_nettype none
module geo2ecef_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire                 clk,
	input  wire                 en,
	input  geo2ecef_pkg::rot_t  rin,
	output geo2ecef_pkg::rot_t  rout
);

	logic signed [33:0] x;
	logic signed [33:0] y;
	logic signed [36:0] z;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [36:0] da;

	always_comb begin
		x = rin.x;
		y = rin.y;
		z = rin.z;
		dx = y >>> STAGE;
		dy = x >>> STAGE;
		da = $signed({5'b0, geo2ecef_pkg::ATAN_TAB[STAGE]});
	end

	// A residual of exactly zero rotates the positive way.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z[36]) begin
				rout.x <= x - dx;
				rout.y <= y + dy;
				rout.z <= z - da;
			end else begin
				rout.x <= x + dx;
				rout.y <= y - dy;
				rout.z <= z + da;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/geo2ecef_sqrt_cell.sv
// One result bit of the pipelined integer square root.
`default_nettype none
module geo2ecef_sqrt_cell (
	input  wire               clk,
	input  wire               en,
	input  geo2ecef_pkg::sq_t din,
	output geo2ecef_pkg::sq_t dout
);

	logic [35:0] rem_n;
	logic [35:0] trial;
	logic        ge;

	always_comb begin
		rem_n = {din.rem[33:0], din.rad[63:62]};
		trial = {2'b00, din.root, 2'b01};
		ge = rem_n >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rad <= {din.rad[61:0], 2'b00};
			dout.rem <= ge ? rem_n - trial : rem_n;
			dout.root <= {din.root[30:0], ge};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/geo2ecef_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none
module geo2ecef_div_cell (
	input  wire               clk,
	input  wire               en,
	input  geo2ecef_pkg::dv_t din,
	output geo2ecef_pkg::dv_t dout
);

	logic [32:0] rem_n;
	logic [32:0] diff;
	logic        ge;

	always_comb begin
		rem_n = {din.rem, din.num[61]};
		diff = rem_n - {1'b0, din.den};
		ge = rem_n >= {1'b0, din.den};
	end

	// Quotient bits shift in where dividend bits shift out.
	always_ff @(posedge clk) begin
		if (en) begin
			dout.num <= {din.num[60:0], ge};
			dout.rem <= ge ? diff[31:0] : rem_n[31:0];
			dout.den <= din.den;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/geo2ecef_mul_rnd.sv
// Signed product scaled down by a power of two, rounded half away from zero.
`default_nettype none
module geo2ecef_mul_rnd #(
	parameter int SHIFT = 30
) (
	input  wire                clk,
	input  wire                en,
	input  wire signed [63:0]  a,
	input  wire signed [33:0]  b,
	output logic signed [63:0] p
);

	localparam logic [95:0] RND = 96'd1 << (SHIFT - 1);

	logic [63:0] am;
	logic [33:0] bm;
	logic [62:0] am_s1;
	logic [31:0] bm_s1;
	logic        neg_s1;
	logic [63:0] pl_s2;
	logic [62:0] ph_s2;
	logic        neg_s2;
	logic [95:0] sum;
	logic [63:0] mag_s3;
	logic        neg_s3;

	always_comb begin
		am = a[63] ? -a : a;
		bm = b[33] ? -b : b;
		sum = {1'b0, ph_s2, 32'b0} + {32'b0, pl_s2} + RND;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1 <= am[62:0];
			bm_s1 <= bm[31:0];
			neg_s1 <= a[63] ^ b[33];
			pl_s2 <= {32'b0, am_s1[31:0]} * {32'b0, bm_s1};
			ph_s2 <= {32'b0, am_s1[62:32]} * {31'b0, bm_s1};
			neg_s2 <= neg_s1;
			if (|sum[95:SHIFT + 63]) begin
				mag_s3 <= 64'h7FFF_FFFF_FFFF_FFFF;
			end else begin
				mag_s3 <= {1'b0, sum[SHIFT + 62:SHIFT]};
			end
			neg_s3 <= neg_s2;
			p <= neg_s3 ? -$signed(mag_s3) : $signed(mag_s3);
		end
	end

endmodule
`default_nettype wire
